// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_top and tb_top; depends on nothing else.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_PEEK    = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;
  } spq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
    logic                      now_empty;
  } spq_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                      insert;
    logic                      remove;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } spq_cmd_t;

  // What a cell hands to its neighbors: its entry and whether the new
  // entry belongs at or before this cell.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic                      ins;
  } spq_link_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic                 clk,
  input  wire spq_pkg::spq_cmd_t    cmd,
  input  wire logic                 occupied,
  input  wire spq_pkg::spq_link_t   left,
  input  wire spq_pkg::spq_link_t   right,
  output spq_pkg::spq_link_t        link
);

  logic signed [spq_pkg::VALUE_W-1:0] value;
  logic [spq_pkg::PRIO_W-1:0]         prio;
  logic                               ins_here;

  // The new entry goes after every entry of lower or equal priority, so it
  // lands ahead of this cell when the cell is free or strictly larger.
  assign ins_here = !occupied || (prio > cmd.prio);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (left.ins) begin
        value <= left.value;
        prio  <= left.prio;
      end else if (ins_here) begin
        value <= cmd.value;
        prio  <= cmd.prio;
      end
    end else if (cmd.remove) begin
      value <= right.value;
      prio  <= right.prio;
    end
  end

  assign link.value = value;
  assign link.prio  = prio;
  assign link.ins   = ins_here;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// the fill counter and the registered result. Depends on spq_pkg, spq_cell.
`default_nettype none

// The queue holds up to CAPACITY entries sorted by ascending priority, with
// earlier arrivals ahead among equal priorities. A command transfer happens
// on a rising edge with start high and busy low; busy is always low, so a
// command may be given in every cycle. Each command yields one result on the
// following cycle: done is high for exactly that cycle and result holds the
// head data (or -1 when empty, 0 for enqueue), the status and the empty flag
// after the command. The receiver cannot stall the block, so it must take
// the result in that cycle. Every slot compares its priority with the new
// entry and shifts with its neighbor at the same edge, which sets the rate
// at one command per cycle.
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire spq_pkg::spq_in_t item,
  output logic                  done,
  output spq_pkg::spq_out_t     result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                empty;
  logic                full;
  logic [CAPACITY-1:0] occupied;
  spq_pkg::spq_cmd_t   cmd;
  spq_pkg::spq_out_t   result_next;

  // link[i] is the output of cell i; the two ends see a free, never-chosen
  // entry so the first cell never takes from its left.
  spq_pkg::spq_link_t  link [CAPACITY];
  spq_pkg::spq_link_t  edge_link;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count == '0);
  assign full   = (count == CW'(CAPACITY));

  assign edge_link.value = '0;
  assign edge_link.prio  = '0;
  assign edge_link.ins   = 1'b0;

  always_comb begin
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    cmd.value  = item.item_value;
    cmd.prio   = item.item_priority;
    count_next = count;
    result_next.result_value = '0;
    result_next.status       = spq_pkg::STATUS_OK;
    unique case (item.kind)
      spq_pkg::KIND_ENQUEUE: begin
        if (full) begin
          result_next.status = spq_pkg::STATUS_FULL;
        end else begin
          cmd.insert = accept;
          count_next = count + CW'(1);
        end
      end
      spq_pkg::KIND_DEQUEUE, spq_pkg::KIND_PEEK: begin
        if (empty) begin
          result_next.result_value = -32'sd1;
          result_next.status       = spq_pkg::STATUS_EMPTY;
        end else begin
          result_next.result_value = link[0].value;
          if (item.kind == spq_pkg::KIND_DEQUEUE) begin
            cmd.remove = accept;
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        // Unused code: no change, zero result.
      end
    endcase
    result_next.now_empty = (count_next == '0);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count);

    spq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occupied (occupied[i]),
      .left     ((i == 0) ? edge_link : link[(i == 0) ? 0 : i - 1]),
      .right    ((i == CAPACITY - 1) ? edge_link
                                     : link[(i == CAPACITY - 1) ? i : i + 1]),
      .link     (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for sorted_priority_queue_top: directed and random commands,
// checked against a behavioral copy of the sorted queue kept in this file.
// Depends on spq_pkg and the queue RTL (sorted_priority_queue_top and spq_cell).
`default_nettype none

module tb_top;

  localparam int QUEUE_DEPTH = spq_pkg::CAPACITY_DEFAULT;
  // The unused code of the kind field; the block answers it without touching the queue.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_COMMANDS = 1750;
  // Cycles without any transfer, in either direction, before the run is declared hung.
  localparam int STALL_LIMIT = 400;
  // Mismatch lines beyond this count are still counted but no longer printed.
  localparam int PRINT_LIMIT = 40;

  typedef logic [spq_pkg::PRIO_W-1:0] prio_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  spq_pkg::spq_in_t  item = '0;
  logic              done;
  spq_pkg::spq_out_t result;

  sorted_priority_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Commands waiting for the driver, and the results the queue owes us, oldest first.
  spq_pkg::spq_in_t  pending_cmds[$];
  spq_pkg::spq_out_t expected_results[$];

  // Shadow copy of the queue contents, head at index 0.
  logic signed [spq_pkg::VALUE_W-1:0] shadow_value[QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]         shadow_prio[QUEUE_DEPTH];
  int                                 shadow_fill = 0;

  int mismatches = 0;
  int sent_count = 0;
  int idle_cycles = 0;

  // Applies one accepted command to the shadow queue and returns the result it must produce.
  function automatic spq_pkg::spq_out_t apply_command(spq_pkg::spq_in_t cmd);
    spq_pkg::spq_out_t res;
    int                pos;
    int                i;
    res = '0;
    case (cmd.kind)
      spq_pkg::KIND_ENQUEUE: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          res.status = spq_pkg::STATUS_FULL;
        end else begin
          // New entry goes behind every entry of equal or smaller priority number.
          pos = 0;
          while (pos < shadow_fill && shadow_prio[pos] <= cmd.item_priority) pos++;
          for (i = shadow_fill; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_prio[i]  = shadow_prio[i-1];
          end
          shadow_value[pos] = cmd.item_value;
          shadow_prio[pos]  = cmd.item_priority;
          shadow_fill++;
        end
      end
      spq_pkg::KIND_DEQUEUE, spq_pkg::KIND_PEEK: begin
        if (shadow_fill == 0) begin
          res.result_value = -1;
          res.status       = spq_pkg::STATUS_EMPTY;
        end else begin
          res.result_value = shadow_value[0];
          if (cmd.kind == spq_pkg::KIND_DEQUEUE) begin
            for (i = 1; i < shadow_fill; i++) begin
              shadow_value[i-1] = shadow_value[i];
              shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_fill--;
          end
        end
      end
      default: ;
    endcase
    res.now_empty = (shadow_fill == 0);
    return res;
  endfunction

  task automatic add_cmd(logic [1:0] kind, logic [spq_pkg::VALUE_W-1:0] value,
                         logic [spq_pkg::PRIO_W-1:0] prio);
    spq_pkg::spq_in_t cmd;
    cmd.kind          = kind;
    cmd.item_value    = value;
    cmd.item_priority = prio;
    pending_cmds.push_back(cmd);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return {1'b1, {(spq_pkg::VALUE_W-1){1'b0}}};
      1: return {1'b0, {(spq_pkg::VALUE_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic prio_t pick_prio();
    int roll;
    roll = $urandom_range(99);
    // Mostly a narrow band so that equal priorities pile up and test arrival order.
    if (roll < 50) return prio_t'($urandom_range(3));
    if (roll < 55) return '0;
    if (roll < 60) return '1;
    return prio_t'($urandom);
  endfunction

  // Builds the random part as runs in a randomly picked mode that leans toward filling, draining
  // or neither, so the queue is driven full and empty many times.
  task automatic build_random_cmds();
    int         counted;
    int         run_len;
    int         mode;
    int         roll;
    logic [1:0] kind;
    counted = 0;
    while (counted < RANDOM_COMMANDS) begin
      mode    = $urandom_range(2);
      run_len = $urandom_range(40, 10);
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          kind = KIND_UNUSED;
        end else if (mode == 0) begin
          kind = (roll < 72) ? spq_pkg::KIND_ENQUEUE :
                 (roll < 88) ? spq_pkg::KIND_DEQUEUE : spq_pkg::KIND_PEEK;
        end else if (mode == 1) begin
          kind = (roll < 20) ? spq_pkg::KIND_ENQUEUE :
                 (roll < 85) ? spq_pkg::KIND_DEQUEUE : spq_pkg::KIND_PEEK;
        end else begin
          kind = (roll < 45) ? spq_pkg::KIND_ENQUEUE :
                 (roll < 75) ? spq_pkg::KIND_DEQUEUE : spq_pkg::KIND_PEEK;
        end
        // Value and priority are randomized for every kind; the block must ignore them for all but enqueue.
        add_cmd(kind, pick_value(), pick_prio());
        if (kind != KIND_UNUSED) counted++;
      end
    end
  endtask

  // Driver: launches one command per transfer, with random gaps except for a back-to-back stretch.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_command(item));
        sent_count++;
      end
      if (start && busy) begin
        // Hold the offered command until the queue takes it.
      end else if (pending_cmds.size() != 0 &&
                   ((sent_count >= 700 && sent_count < 1000) || $urandom_range(99) >= 29)) begin
        item  <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and watchdog: every done cycle carries one result that must match the oldest
  // expectation; a long stretch with no transfer at all ends the run.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", result.result_value, 0);
        end else begin
          automatic spq_pkg::spq_out_t want = expected_results.pop_front();
          if (result.result_value !== want.result_value)
            report_mismatch("result_value", result.result_value, want.result_value);
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.now_empty !== want.now_empty)
            report_mismatch("now_empty", result.now_empty, want.now_empty);
        end
      end
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed part: reads of an empty queue, the unused kind, extreme values and priorities,
    // arrival order among equal priorities, then draining back past empty.
    add_cmd(spq_pkg::KIND_PEEK,    '0, '0);
    add_cmd(spq_pkg::KIND_DEQUEUE, '1, '1);
    add_cmd(KIND_UNUSED,           '1, '1);
    add_cmd(spq_pkg::KIND_ENQUEUE, {1'b1, {(spq_pkg::VALUE_W-1){1'b0}}}, '1);
    add_cmd(spq_pkg::KIND_ENQUEUE, {1'b0, {(spq_pkg::VALUE_W-1){1'b1}}}, '0);
    add_cmd(spq_pkg::KIND_ENQUEUE, '1, '1);
    add_cmd(spq_pkg::KIND_ENQUEUE, 32'h0000_0001, 8'd7);
    add_cmd(spq_pkg::KIND_ENQUEUE, 32'h0000_0002, 8'd7);
    add_cmd(KIND_UNUSED,           '0, '0);
    add_cmd(spq_pkg::KIND_PEEK,    '1, '1);
    repeat (5) add_cmd(spq_pkg::KIND_DEQUEUE, '0, '0);
    add_cmd(spq_pkg::KIND_DEQUEUE, '0, '0);
    add_cmd(spq_pkg::KIND_PEEK,    '0, '0);
    build_random_cmds();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Keep running to catch any stray result after the last expected one.
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
